// File: rtl/crr_pkg.sv
// Shared types and constants for the command ring with reserved slots.
// Used by crr_slot_mem and command_ring_with_reserved_slots_top; no dependencies.
package crr_pkg;

  // Default ring depth; a power of two from 2 to 1024.
  localparam int DEPTH_DEFAULT = 16;

  localparam int SEQ_W   = 48;
  localparam int OWNER_W = 16;
  localparam int EPOCH_W = 32;
  localparam int WORD_W  = 32;
  localparam int RES_W   = 4;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [1:0] OP_PUBLISH = 2'd0;
  localparam logic [1:0] OP_CONSUME = 2'd1;
  localparam logic [1:0] OP_CLOSE   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_ID       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_ID       = 2'd2;

  // Configuration reset values.
  localparam logic [RES_W-1:0]   CRITICAL_SLOTS_RESET = 4'd4;
  localparam logic [OWNER_W-1:0] OWNER_ID_RESET       = 16'd0;
  localparam logic [EPOCH_W-1:0] EPOCH_ID_RESET       = 32'd1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PUBLISHED   = 3'd0,
    ST_CLOSED      = 3'd1,
    ST_BAD_SEQ     = 3'd2,
    ST_BAD_CMD     = 3'd3,
    ST_CRIT_RETRY  = 3'd4,
    ST_ORD_FULL    = 3'd5,
    ST_POPPED      = 3'd6,
    ST_EMPTY       = 3'd7
  } status_t;

  // One input item.
  typedef struct packed {
    logic [1:0]         op;
    logic [SEQ_W-1:0]   sequence_req;
    logic [OWNER_W-1:0] owner;
    logic [EPOCH_W-1:0] epoch;
    logic               command_ok;
    logic               is_critical;
    logic [WORD_W-1:0]  command_word;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [2:0]        status;
    logic [SEQ_W-1:0]  out_sequence;
    logic [WORD_W-1:0] out_command;
    logic              drained;
  } rsp_t;

  // One stored ring entry.
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] word;
  } slot_t;

endpackage

// File: rtl/crr_slot_mem.sv
// Ring storage: one write port and a registered read port that prefetches the head entry.
// Depends on crr_pkg for the slot_t entry type.
module crr_slot_mem #(
  parameter int DEPTH = crr_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  crr_pkg::slot_t           wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output crr_pkg::slot_t           head
);
  import crr_pkg::*;

  slot_t mem [DEPTH];

  // Write the published entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the entry at next cycle's read pointer; a same-cycle write to it
  // is forwarded so a freshly published entry is visible at once.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      head <= wr_data;
    end else begin
      head <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/command_ring_with_reserved_slots_top.sv
// Command ring with reserved slots: top level with control, configuration and handshakes.
// Depends on crr_pkg and crr_slot_mem.

// A single-producer single-consumer command queue of DEPTH entries. Each item is a
// publish, consume or close and yields exactly one result item. Ordinary publishes may
// fill only DEPTH minus critical_slots entries; critical ones may fill the whole ring.
// The block takes one item per cycle sustained. An accepted item passes through the
// input register and then the result register; a stalled result holds the input
// register and stalls the sender. The rate is set by the ring memory, which has one
// write port and one read port whose registered output always holds the oldest
// entry, prefetched ahead. Configuration writes belong only to idle periods.
module command_ring_with_reserved_slots_top #(
  parameter int DEPTH = crr_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  crr_pkg::cmd_t                    cmd,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output crr_pkg::rsp_t                    rsp,
  input  logic                             cfg_we,
  input  logic [crr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crr_pkg::CFG_W-1:0]        cfg_data
);
  import crr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int LIM_W = ((PTR_W > RES_W) ? PTR_W : RES_W) + 1;

  // Configuration registers.
  logic [RES_W-1:0]   critical_slots;
  logic [OWNER_W-1:0] owner_id;
  logic [EPOCH_W-1:0] epoch_id;

  // Ring state.
  logic [PTR_W-1:0] write_pointer, write_pointer_next;
  logic [PTR_W-1:0] read_pointer, read_pointer_next;
  logic [SEQ_W-1:0] last_seq, last_seq_next;
  logic             closed, closed_next;

  // Input register and handshake.
  cmd_t held;
  logic held_valid;
  logic process;
  logic cmd_take;

  // Derived values for the held item.
  logic [PTR_W-1:0] fill;
  logic [LIM_W-1:0] limit;
  logic             wr_en;
  slot_t            wr_data;
  slot_t            head;
  rsp_t             rsp_next;

  assign process   = held_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = held_valid && !process;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      critical_slots <= CRITICAL_SLOTS_RESET;
      owner_id       <= OWNER_ID_RESET;
      epoch_id       <= EPOCH_ID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRITICAL_SLOTS: critical_slots <= cfg_data[RES_W-1:0];
        CFG_OWNER_ID:       owner_id       <= cfg_data[OWNER_W-1:0];
        CFG_EPOCH_ID:       epoch_id       <= cfg_data[EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd_take) begin
      held_valid <= 1'b1;
    end else if (process) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      held <= cmd;
    end
  end

  // Publish limit: critical items may use every entry, ordinary ones stop short
  // of the reserve, and a reserve at or above the depth shuts them out.
  assign fill = write_pointer - read_pointer;

  always_comb begin
    if (held.is_critical) begin
      limit = LIM_W'(DEPTH);
    end else if (LIM_W'(critical_slots) >= LIM_W'(DEPTH)) begin
      limit = '0;
    end else begin
      limit = LIM_W'(DEPTH) - LIM_W'(critical_slots);
    end
  end

  // Decode the held item and form the next state and the result.
  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    last_seq_next      = last_seq;
    closed_next        = closed;
    wr_en              = 1'b0;
    wr_data.seq        = held.sequence_req;
    wr_data.word       = held.command_word;
    rsp_next.status       = ST_CLOSED;
    rsp_next.out_sequence = '0;
    rsp_next.out_command  = '0;

    if (held_valid) begin
      case (held.op)
        OP_PUBLISH: begin
          if (closed) begin
            rsp_next.status = ST_CLOSED;
          end else if (held.sequence_req <= last_seq) begin
            rsp_next.status = ST_BAD_SEQ;
          end else if ((held.owner != owner_id) || (held.epoch != epoch_id) ||
                       !held.command_ok) begin
            rsp_next.status = ST_BAD_CMD;
          end else if (LIM_W'(fill) >= limit) begin
            rsp_next.status = held.is_critical ? ST_CRIT_RETRY : ST_ORD_FULL;
          end else begin
            rsp_next.status    = ST_PUBLISHED;
            wr_en              = process;
            last_seq_next      = held.sequence_req;
            write_pointer_next = write_pointer + PTR_W'(1);
          end
        end
        OP_CONSUME: begin
          if (fill == '0) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            rsp_next.status       = ST_POPPED;
            rsp_next.out_sequence = head.seq;
            rsp_next.out_command  = head.word;
            read_pointer_next     = read_pointer + PTR_W'(1);
          end
        end
        default: begin
          // Close, and the unused code, set the sticky flag.
          rsp_next.status = ST_CLOSED;
          closed_next     = 1'b1;
        end
      endcase
    end

    rsp_next.drained = closed_next && (write_pointer_next == read_pointer_next);

    if (!process) begin
      write_pointer_next = write_pointer;
      read_pointer_next  = read_pointer;
      last_seq_next      = last_seq;
      closed_next        = closed;
    end
  end

  // Ring state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      last_seq      <= '0;
      closed        <= 1'b0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      last_seq      <= last_seq_next;
      closed        <= closed_next;
    end
  end

  // Result register; it frees up when the consumer takes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (process) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      rsp <= rsp_next;
    end
  end

  // Ring storage; the read side tracks next cycle's read pointer.
  crr_slot_mem #(
    .DEPTH (DEPTH)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (wr_en && !rst),
    .wr_addr (write_pointer[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rst ? '0 : read_pointer_next[IDX_W-1:0]),
    .head    (head)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for command_ring_with_reserved_slots_top.
// Depends on crr_pkg and the ring RTL; it predicts every result item itself and compares in order.
`timescale 1ns / 100ps

module tb_top;
  import crr_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEFAULT;
  localparam int PTR_W = $clog2(RING_DEPTH) + 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 300;
  localparam int TAIL_ITEMS = 40;
  // The unused operation code; the block treats it as a close.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // Predicted ring state and register copies.
  logic [PTR_W-1:0] model_wr = '0;
  logic [PTR_W-1:0] model_rd = '0;
  logic [SEQ_W-1:0] model_last_seq = '0;
  logic model_closed = 1'b0;
  slot_t model_slots[RING_DEPTH];
  logic [RES_W-1:0] model_reserve = CRITICAL_SLOTS_RESET;
  logic [OWNER_W-1:0] model_owner = OWNER_ID_RESET;
  logic [EPOCH_W-1:0] model_epoch = EPOCH_ID_RESET;

  rsp_t expected_results[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  command_ring_with_reserved_slots_top #(
    .DEPTH(RING_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Compute the result of one accepted item and advance the predicted ring.
  function automatic rsp_t predict_ring_result(input cmd_t item);
    rsp_t r;
    logic [PTR_W-1:0] fill;
    int limit;
    r = '0;
    fill = model_wr - model_rd;
    case (item.op)
      OP_PUBLISH: begin
        if (model_closed) begin
          r.status = ST_CLOSED;
        end else if (item.sequence_req <= model_last_seq) begin
          r.status = ST_BAD_SEQ;
        end else if (item.owner != model_owner || item.epoch != model_epoch ||
                     !item.command_ok) begin
          r.status = ST_BAD_CMD;
        end else begin
          if (item.is_critical) begin
            limit = RING_DEPTH;
          end else if (int'(model_reserve) >= RING_DEPTH) begin
            limit = 0;
          end else begin
            limit = RING_DEPTH - int'(model_reserve);
          end
          if (int'(fill) >= limit) begin
            r.status = item.is_critical ? ST_CRIT_RETRY : ST_ORD_FULL;
          end else begin
            model_slots[model_wr[PTR_W-2:0]] = '{seq: item.sequence_req,
                                                 word: item.command_word};
            model_last_seq = item.sequence_req;
            model_wr = model_wr + PTR_W'(1);
            r.status = ST_PUBLISHED;
          end
        end
      end
      OP_CONSUME: begin
        if (fill == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_sequence = model_slots[model_rd[PTR_W-2:0]].seq;
          r.out_command = model_slots[model_rd[PTR_W-2:0]].word;
          model_rd = model_rd + PTR_W'(1);
          r.status = ST_POPPED;
        end
      end
      default: begin
        model_closed = 1'b1;
        r.status = ST_CLOSED;
      end
    endcase
    r.drained = model_closed && (model_wr == model_rd);
    return r;
  endfunction

  function automatic cmd_t random_cmd_bits();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(cmd_t)-1:0];
  endfunction

  // A publish that passes the scope and upstream checks, with a random word.
  function automatic cmd_t make_publish(input logic [SEQ_W-1:0] seq, input logic critical);
    cmd_t c;
    c = random_cmd_bits();
    c.op = OP_PUBLISH;
    c.sequence_req = seq;
    c.owner = model_owner;
    c.epoch = model_epoch;
    c.command_ok = 1'b1;
    c.is_critical = critical;
    return c;
  endfunction

  function automatic cmd_t make_consume();
    cmd_t c;
    c = random_cmd_bits();
    c.op = OP_CONSUME;
    return c;
  endfunction

  // Mostly well-formed publishes and consumes; some broken publishes and pure noise.
  function automatic cmd_t random_ring_item(input int publish_pct);
    cmd_t c;
    logic [SEQ_W-1:0] step;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      c = random_cmd_bits();
      c.op = $urandom_range(1) ? OP_CONSUME : OP_PUBLISH;
    end else if ($urandom_range(99) < publish_pct) begin
      if ($urandom_range(9) == 0) begin
        step = SEQ_W'($urandom_range(65535) + 1);
      end else begin
        step = SEQ_W'($urandom_range(4, 1));
      end
      c = make_publish(model_last_seq + step, $urandom_range(99) < 35);
      pick = $urandom_range(99);
      if (pick < 6) begin
        c.command_ok = 1'b0;
      end else if (pick < 10) begin
        c.owner[$urandom_range(OWNER_W - 1)] ^= 1'b1;
      end else if (pick < 14) begin
        c.epoch[$urandom_range(EPOCH_W - 1)] ^= 1'b1;
      end else if (pick < 19) begin
        // A stale sequence: equal to or just below the last accepted one.
        c.sequence_req = model_last_seq;
        if (model_last_seq != '0 && $urandom_range(1)) begin
          c.sequence_req = model_last_seq - SEQ_W'(1);
        end
      end
    end else begin
      c = make_consume();
    end
    return c;
  endfunction

  // Offer one item, hold it until accepted, then record its expected result.
  task automatic send_item(input cmd_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    expected_results.push_back(predict_ring_result(item));
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic settle_ring();
    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles; only called while the ring is idle.
  task automatic apply_settings(input logic [RES_W-1:0] reserve,
                                input logic [OWNER_W-1:0] owner,
                                input logic [EPOCH_W-1:0] epoch);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CRITICAL_SLOTS;
    cfg_data <= CFG_W'(reserve);
    @(posedge clk);
    cfg_index <= CFG_OWNER_ID;
    cfg_data <= CFG_W'(owner);
    @(posedge clk);
    cfg_index <= CFG_EPOCH_ID;
    cfg_data <= CFG_W'(epoch);
    @(posedge clk);
    cfg_we <= 1'b0;
    model_reserve = reserve;
    model_owner = owner;
    model_epoch = epoch;
  endtask

  // Register reset values, the sequence and command rejections and their priority, push and pop.
  task automatic test_directed_checks();
    cmd_t c;
    send_item(make_consume());
    send_item(make_publish(SEQ_W'(0), 1'b0));
    c = make_publish(SEQ_W'(0), 1'b0);
    c.owner = ~model_owner;
    send_item(c);
    c = make_publish(SEQ_W'(1), 1'b0);
    c.command_ok = 1'b0;
    send_item(c);
    c = make_publish(SEQ_W'(1), 1'b0);
    c.owner = '1;
    send_item(c);
    c = make_publish(SEQ_W'(1), 1'b1);
    c.epoch = '0;
    send_item(c);
    c = make_publish(SEQ_W'(1), 1'b0);
    c.command_word = '0;
    send_item(c);
    c = make_publish(SEQ_W'(2), 1'b1);
    c.command_word = '1;
    send_item(c);
    send_item(make_publish(SEQ_W'(2), 1'b0));
    repeat (3) send_item(make_consume());
    settle_ring();
  endtask

  // Random traffic in bursts that alternately fill and empty the ring.
  task automatic run_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int publish_pct;
    publish_pct = 25;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        publish_pct = (publish_pct > 50) ? 25 : 80;
      end
      // Let every pending result come back once in the middle of the phase.
      if (i == count / 2) begin
        settle_ring();
      end
      send_item(random_ring_item(publish_pct));
    end
    settle_ring();
  endtask

  // The largest sequence is accepted once, and nothing can follow it.
  task automatic test_sequence_ceiling();
    repeat (2) send_item(make_consume());
    send_item(make_publish('1, 1'b1));
    send_item(make_publish('1, 1'b0));
  endtask

  // Close, the unused code, pops after close, the drained flag and random leftovers.
  task automatic test_close_and_drain();
    cmd_t c;
    c = make_publish('1, 1'b1);
    c.op = OP_CLOSE;
    send_item(c);
    send_item(make_publish('1, 1'b1));
    c.op = OP_UNUSED;
    send_item(c);
    while (model_wr != model_rd) send_item(make_consume());
    send_item(make_consume());
    c.op = OP_CLOSE;
    send_item(c);
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      send_item(random_cmd_bits());
    end
    settle_ring();
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    rsp_stall <= !rst && ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result item with no item pending, status %0d", rsp.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp.status);
          error_count++;
        end
        if (rsp.out_sequence !== want.out_sequence) begin
          $error("out_sequence expected %0h actual %0h", want.out_sequence, rsp.out_sequence);
          error_count++;
        end
        if (rsp.out_command !== want.out_command) begin
          $error("out_command expected %0h actual %0h", want.out_command, rsp.out_command);
          error_count++;
        end
        if (rsp.drained !== want.drained) begin
          $error("drained expected %0b actual %0b", want.drained, rsp.drained);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_stall === 1'b0) ||
        (rsp_valid === 1'b1 && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_checks();
    apply_settings(4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    run_random_traffic(PHASE_ITEMS, 0, 0);
    apply_settings(4'd0, 16'h0000, 32'd1);
    run_random_traffic(PHASE_ITEMS, 60, 0);
    apply_settings(4'd4, 16'($urandom), 32'($urandom_range(32'hFFFF_FFFE) + 1));
    run_random_traffic(PHASE_ITEMS, 0, 60);
    apply_settings(4'd9, 16'h5A5A, 32'd0);
    run_random_traffic(PHASE_ITEMS, 27, 27);
    apply_settings(4'd1, 16'($urandom), 32'($urandom));
    run_random_traffic(PHASE_ITEMS, 0, 0);
    sender_idle_pct = 27;
    receiver_stall_pct = 27;
    test_sequence_ceiling();
    test_close_and_drain();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
